>>> design/ffra_pkg.sv
// Shared types and constants for the first-fit region allocator.
// Used by first_fit_region_allocator_unit; no other dependencies.
package ffra_pkg;

  // Default number of entries in the free-region table.
  localparam int unsigned DefaultTableEntries = 64;

  // Rounding to a 4 KiB granule: add, then mask.
  localparam logic [31:0] RoundAdd  = 32'h0000_0FFF;
  localparam logic [31:0] RoundMask = 32'hFFFF_F000;

  // Request kinds.
  typedef enum logic [1:0] {
    MODE_ALLOC    = 2'd0,
    MODE_ALLOC_4K = 2'd1,
    MODE_FREE     = 2'd2,
    MODE_FREE_4K  = 2'd3
  } mode_e;

  // Result codes.
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_ALLOC_FAIL = 2'd1,
    STATUS_FREE_DROP  = 2'd2
  } status_e;

  // One request transaction.
  typedef struct packed {
    mode_e       mode;
    logic [31:0] request_address;
    logic [31:0] request_size;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
    logic [31:0] free_bytes;
    logic [6:0]  peak_entries;
    logic [31:0] dropped_frees;
    logic [31:0] dropped_bytes;
  } rsp_t;

  // One free-region table entry as stored in memory.
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] length;
  } entry_t;

endpackage

>>> design/ffra_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module ffra_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/first_fit_region_allocator_unit.sv
// Top level of the first-fit region allocator: sequencer, counters and table.
// Depends on ffra_pkg and ffra_ram.
//
// The block keeps an address-sorted table of free regions in a single memory
// with one write and one registered read port, and handles one transaction at
// a time. An allocate scans the table from the start at one entry per cycle
// until the first region that is large enough; a free scans until the first
// base above the freed address and then merges or inserts. Removing or
// inserting an entry moves every later entry by one place, again one entry per
// cycle through the same memory port. A removal starts where the scan stopped;
// an insert starts at the end of the table and works back to that place. A free
// tests and then applies a merge between its scan and any shift. The input is
// ready only between items; a finished result sits in an output register, so
// the next request is accepted while that result still waits to be taken. The
// free-byte total is kept as a running sum, and the table memory needs no
// clearing after reset.
module first_fit_region_allocator_unit
  import ffra_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DefaultTableEntries
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CountMax = CW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FR_TEST,
    S_FR_APPLY,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_DONE
  } state_e;

  state_e        state_q;
  logic [CW-1:0] idx_q;
  logic          chk_v_q;
  logic [CW-1:0] pos_q;
  entry_t        prev_q;
  entry_t        cur_q;
  logic [31:0]   addr_q;
  logic [31:0]   size_q;
  logic          is_free_q;
  logic [31:0]   granted_q;
  status_e       status_q;
  logic [31:0]   total_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] peak_q;
  logic [31:0]   drop_cnt_q;
  logic [31:0]   drop_bytes_q;
  logic          prev_merge_q;
  logic          cur_merge_q;
  logic [31:0]   len_ps_q;
  logic [31:0]   len_cs_q;
  logic          out_valid_q;
  rsp_t          out_data_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  logic          scan_hit;
  logic          scan_end;
  logic          issue;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] idx_m2;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] pos_m1;
  logic [CW-1:0] pos_p1;
  logic [31:0]   size_rnd;
  logic [31:0]   peak_ext;

  assign idx_m1 = idx_q - CW'(1);
  assign idx_m2 = idx_q - CW'(2);
  assign idx_p1 = idx_q + CW'(1);
  assign pos_m1 = pos_q - CW'(1);
  assign pos_p1 = pos_q + CW'(1);

  // Request size, rounded up to 4 KiB in the rounding modes.
  always_comb begin
    size_rnd = in_data_i.request_size;
    if (in_data_i.mode == MODE_ALLOC_4K || in_data_i.mode == MODE_FREE_4K) begin
      size_rnd = (in_data_i.request_size + RoundAdd) & RoundMask;
    end
  end

  // Scan compare on the entry that the memory returns this cycle.
  assign scan_hit = chk_v_q && (is_free_q ? (ram_rdata.base > addr_q)
                                          : (ram_rdata.length >= size_q));
  assign scan_end = (idx_q == count_q);

  // A read is issued whenever a scan or a shift still has entries to visit.
  always_comb begin
    issue = 1'b0;
    case (state_q)
      S_SCAN:     issue = !scan_hit && !scan_end;
      S_SHIFT_DN: issue = (idx_q < count_q);
      S_SHIFT_UP: issue = (idx_q > pos_q);
      default:    issue = 1'b0;
    endcase
  end

  // Memory addressing and write data.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_m1[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[AW-1:0];
    unique case (state_q)
      S_SCAN: begin
        // Shrink the chosen region unless it empties completely.
        if (scan_hit && !is_free_q && (ram_rdata.length != size_q)) begin
          ram_we           = 1'b1;
          ram_waddr        = idx_m1[AW-1:0];
          ram_wdata.base   = ram_rdata.base + size_q;
          ram_wdata.length = ram_rdata.length - size_q;
        end
      end
      S_FR_APPLY: begin
        if (prev_merge_q) begin
          ram_we           = 1'b1;
          ram_waddr        = pos_m1[AW-1:0];
          ram_wdata.base   = prev_q.base;
          ram_wdata.length = cur_merge_q ? (len_ps_q + cur_q.length) : len_ps_q;
        end else if (cur_merge_q) begin
          ram_we           = 1'b1;
          ram_waddr        = pos_q[AW-1:0];
          ram_wdata.base   = addr_q;
          ram_wdata.length = len_cs_q;
        end
      end
      S_SHIFT_DN: begin
        // Entry idx-1 moves down to idx-2.
        ram_we    = chk_v_q;
        ram_waddr = idx_m2[AW-1:0];
      end
      S_SHIFT_UP: begin
        // Entry idx moves up to idx+1; the new region lands once the gap is open.
        ram_raddr = idx_m1[AW-1:0];
        if (chk_v_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_p1[AW-1:0];
        end else if (idx_q == pos_q) begin
          ram_we           = 1'b1;
          ram_waddr        = pos_q[AW-1:0];
          ram_wdata.base   = addr_q;
          ram_wdata.length = size_q;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ffra_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign peak_ext = 32'(peak_q);

  // Sequencer, counters and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      chk_v_q      <= 1'b0;
      pos_q        <= '0;
      prev_q       <= '0;
      cur_q        <= '0;
      addr_q       <= '0;
      size_q       <= '0;
      is_free_q    <= 1'b0;
      granted_q    <= '0;
      status_q     <= STATUS_OK;
      total_q      <= '0;
      count_q      <= '0;
      peak_q       <= '0;
      drop_cnt_q   <= '0;
      drop_bytes_q <= '0;
      prev_merge_q <= 1'b0;
      cur_merge_q  <= 1'b0;
      len_ps_q     <= '0;
      len_cs_q     <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      // A taken result frees the output register; the done state refills it itself.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      // Shared read-stream bookkeeping for scans and shifts.
      if (issue) begin
        idx_q   <= (state_q == S_SHIFT_UP) ? idx_m1 : idx_p1;
        chk_v_q <= 1'b1;
      end else begin
        chk_v_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            addr_q    <= in_data_i.request_address;
            size_q    <= size_rnd;
            is_free_q <= (in_data_i.mode == MODE_FREE || in_data_i.mode == MODE_FREE_4K);
            granted_q <= '0;
            status_q  <= STATUS_OK;
            idx_q     <= '0;
            state_q   <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (scan_hit) begin
            if (is_free_q) begin
              pos_q   <= idx_m1;
              cur_q   <= ram_rdata;
              state_q <= S_FR_TEST;
            end else begin
              granted_q <= ram_rdata.base;
              status_q  <= STATUS_OK;
              total_q   <= total_q - size_q;
              // An emptied region is removed; idx already points past it.
              state_q   <= (ram_rdata.length == size_q) ? S_SHIFT_DN : S_DONE;
            end
          end else if (scan_end) begin
            if (is_free_q) begin
              pos_q <= idx_q;
              if (chk_v_q) begin
                prev_q <= ram_rdata;
              end
              state_q <= S_FR_TEST;
            end else begin
              granted_q <= '0;
              status_q  <= STATUS_ALLOC_FAIL;
              state_q   <= S_DONE;
            end
          end else if (is_free_q && chk_v_q) begin
            prev_q <= ram_rdata;
          end
        end

        S_FR_TEST: begin
          prev_merge_q <= (pos_q != '0) && ((prev_q.base + prev_q.length) == addr_q);
          cur_merge_q  <= (pos_q != count_q) && ((addr_q + size_q) == cur_q.base);
          len_ps_q     <= prev_q.length + size_q;
          len_cs_q     <= cur_q.length + size_q;
          state_q      <= S_FR_APPLY;
        end

        S_FR_APPLY: begin
          if (prev_merge_q) begin
            total_q <= total_q + size_q;
            if (cur_merge_q) begin
              // Following entry was absorbed; close its slot.
              idx_q   <= pos_p1;
              state_q <= S_SHIFT_DN;
            end else begin
              state_q <= S_DONE;
            end
          end else if (cur_merge_q) begin
            total_q <= total_q + size_q;
            state_q <= S_DONE;
          end else if (count_q < CountMax) begin
            total_q <= total_q + size_q;
            idx_q   <= count_q;
            state_q <= S_SHIFT_UP;
          end else begin
            status_q     <= STATUS_FREE_DROP;
            drop_cnt_q   <= drop_cnt_q + 32'd1;
            drop_bytes_q <= drop_bytes_q + size_q;
            state_q      <= S_DONE;
          end
        end

        S_SHIFT_DN: begin
          if (!chk_v_q && !issue) begin
            count_q <= count_q - CW'(1);
            state_q <= S_DONE;
          end
        end

        S_SHIFT_UP: begin
          if (!chk_v_q && (idx_q == pos_q)) begin
            count_q <= count_q + CW'(1);
            if (peak_q < count_q + CW'(1)) begin
              peak_q <= count_q + CW'(1);
            end
            state_q <= S_DONE;
          end
        end

        S_DONE: begin
          // Wait until the output register is free, then post the result.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q                <= 1'b1;
            out_data_q.granted_address <= granted_q;
            out_data_q.status          <= status_q;
            out_data_q.free_bytes      <= total_q;
            out_data_q.peak_entries    <= peak_ext[6:0];
            out_data_q.dropped_frees   <= drop_cnt_q;
            out_data_q.dropped_bytes   <= drop_bytes_q;
            state_q                    <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The table never holds more entries than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountMax)
    else $error("region count exceeds table size");

  // The peak entry count never falls below the current count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= count_q)
    else $error("peak entry count below current count");

  // An accepted request always starts a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_SCAN)
    else $error("accepted request did not start a scan");

  // Table writes never land beyond the occupied part plus one slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) <= count_q))
    else $error("table write outside occupied range");

endmodule
